// File: hw/rtl/bfa_pkg.sv
`default_nettype none

package bfa_pkg;

    localparam int HEAP_WORDS  = 4096;
    localparam int ALIGN_BYTES = 16;
    localparam int OVERHEAD    = 16;
    localparam int IDX_W       = $clog2(HEAP_WORDS);
    localparam int TOP_W       = IDX_W + 1;

    localparam logic [31:0] TAG_USED     = 32'd1;
    localparam logic [31:0] TAG_PREVFREE = 32'd2;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_RELEASE = 2'd1;
    localparam logic [1:0] FN_RESIZE  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/best_fit_boundary_tag_allocator.sv
`default_nettype none
// Channel | Valid   | Ready   | Word
// in      | i_valid | o_ready | i_func, i_req_size, i_addr, i_addr_present
// out     | o_valid | i_ready | o_result_addr, o_result_present, o_status, o_moved
//
// Walks: an item reads one tag per heap block for each walk of the tag store
// (one tag read per cycle through the single store port); outside the walks it
// passes through accept, fit decision, split, release and hand-off.
// Resize may walk twice (check, then best fit).
// Reset: i_rst_n clears heap top, final-block pointer and control; the store
// itself is not cleared, and no legal sequence reads an unwritten word.
// Stalls: a finished word waits in the output register; the next item is taken
// while it waits, and the engine holds only when a second result is ready.

module best_fit_boundary_tag_allocator
    import bfa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_req_size,
    input  wire logic [13:0] i_addr,
    input  wire logic        i_addr_present,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [13:0]      o_result_addr,
    output logic             o_result_present,
    output logic             o_status,
    output logic             o_moved
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WALK   = 4'd1;
    localparam logic [3:0] S_FIT    = 4'd2;
    localparam logic [3:0] S_SPL1   = 4'd3;
    localparam logic [3:0] S_SPL2   = 4'd4;
    localparam logic [3:0] S_SPL3   = 4'd5;
    localparam logic [3:0] S_NXTWR  = 4'd6;
    localparam logic [3:0] S_GROW   = 4'd7;
    localparam logic [3:0] S_RESZ   = 4'd8;
    localparam logic [3:0] S_RELRD  = 4'd9;
    localparam logic [3:0] S_RELPRV = 4'd10;
    localparam logic [3:0] S_RELMID = 4'd11;
    localparam logic [3:0] S_RELNXT = 4'd12;
    localparam logic [3:0] S_RELW1  = 4'd13;
    localparam logic [3:0] S_RELW2  = 4'd14;
    localparam logic [3:0] S_FIN    = 4'd15;

    // Tag store: one write and one registered read per cycle.
    logic [31:0] r_mem [0:HEAP_WORDS-1];
    logic [31:0] r_rd;

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_w, n_w;        // walk pointer
    logic [IDX_W-1:0] r_h, n_h;        // block being checked or released
    logic [IDX_W-1:0] r_p, n_p;        // best fit so far
    logic             r_find, n_find;  // walk looks for r_h instead of a fit
    logic             r_resz, n_resz;  // find walk feeds resize
    logic             r_move, n_move;  // resize relocates
    logic             r_found, n_found;
    logic [31:0]      r_best, n_best;
    logic [16:0]      r_need, n_need;
    logic [15:0]      r_req, n_req;
    logic [13:0]      r_addr, n_addr;
    logic [31:0]      r_size, n_size;
    logic             r_islast, n_islast;
    logic [TOP_W-1:0] r_top, n_top;
    logic [TOP_W-1:0] r_last, n_last;
    logic [13:0]      r_res_addr, n_res_addr;
    logic             r_res_pres, n_res_pres;
    logic             r_res_stat, n_res_stat;
    logic             r_res_mov, n_res_mov;
    logic             r_ovalid, n_ovalid;
    logic [13:0]      r_o_addr, n_o_addr;
    logic             r_o_pres, n_o_pres;
    logic             r_o_stat, n_o_stat;
    logic             r_o_mov, n_o_mov;

    logic             n_we;
    logic [IDX_W-1:0] n_wa, n_ra;
    logic [31:0]      n_wd;

    // Walk and address arithmetic on the tag just read.
    logic [31:0] t_sz, wnx, rnx, rft, sft, nxtp, os;
    logic        t_small, wnx_in;
    logic [16:0] need_in;
    logic        addr_ok;
    logic [IDX_W-1:0] h_in;

    always_comb begin
        t_sz    = {r_rd[31:2], 2'b00};
        t_small = (r_rd[31:2] == 30'd0);
        wnx     = 32'(r_w) + 32'(r_rd[31:2]);
        wnx_in  = wnx < 32'(r_top);
        rnx     = 32'(r_h) + 32'(r_size[31:2]);
        rft     = rnx - 32'd1;
        nxtp    = 32'(r_p) + 32'(r_need[16:2]);
        sft     = 32'(r_p) + 32'(r_best[31:2]) - 32'd1;
        os      = t_sz;
        need_in = (17'(i_req_size) + 17'(OVERHEAD + ALIGN_BYTES - 1))
                  & ~17'(ALIGN_BYTES - 1);
        addr_ok = i_addr_present && (i_addr >= 14'(OVERHEAD)) && (i_addr[1:0] == 2'b00);
        h_in    = IDX_W'((i_addr - 14'(OVERHEAD)) >> 2);
    end

    always_comb begin
        logic do_fit;
        logic do_find;
        logic do_adone;
        logic [IDX_W-1:0] ap;
        do_fit   = 1'b0;
        do_find  = 1'b0;
        do_adone = 1'b0;
        ap       = r_p;

        n_state = r_state;  n_w = r_w;        n_h = r_h;        n_p = r_p;
        n_find = r_find;    n_resz = r_resz;  n_move = r_move;  n_found = r_found;
        n_best = r_best;    n_need = r_need;  n_req = r_req;    n_addr = r_addr;
        n_size = r_size;    n_islast = r_islast;
        n_top = r_top;      n_last = r_last;
        n_res_addr = r_res_addr; n_res_pres = r_res_pres;
        n_res_stat = r_res_stat; n_res_mov = r_res_mov;
        n_ovalid = r_ovalid && !i_ready;
        n_o_addr = r_o_addr; n_o_pres = r_o_pres; n_o_stat = r_o_stat; n_o_mov = r_o_mov;
        n_we = 1'b0;  n_wa = '0;  n_wd = '0;  n_ra = r_w;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req = i_req_size;  n_addr = i_addr;  n_need = need_in;
                    n_h = h_in;  n_move = 1'b0;  n_resz = 1'b0;
                    n_res_addr = '0;  n_res_pres = 1'b0;
                    n_res_stat = 1'b0;  n_res_mov = 1'b0;
                    n_state = S_FIN;
                    case (i_func)
                        FN_ALLOC: begin
                            if (i_req_size != 16'd0) do_fit = 1'b1;
                        end
                        FN_RELEASE: begin
                            if (addr_ok) do_find = 1'b1;
                        end
                        FN_RESIZE: begin
                            if (i_req_size == 16'd0) begin
                                if (addr_ok) do_find = 1'b1;
                            end else if (!i_addr_present) begin
                                do_fit = 1'b1;
                            end else if (addr_ok) begin
                                do_find = 1'b1;
                                n_resz  = 1'b1;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_WALK: begin
                if (r_find) begin
                    if (r_w == r_h) begin
                        if (r_rd[0]) begin
                            n_ra    = r_h;
                            n_state = r_resz ? S_RESZ : S_RELRD;
                        end else begin
                            n_state = S_FIN;
                        end
                    end else if (r_w > r_h || t_small || !wnx_in) begin
                        n_state = S_FIN;
                    end else begin
                        n_w  = wnx[IDX_W-1:0];
                        n_ra = wnx[IDX_W-1:0];
                    end
                end else begin
                    if (!r_rd[0] && t_sz >= 32'(r_need) && t_sz < r_best) begin
                        n_best  = t_sz;
                        n_p     = r_w;
                        n_found = 1'b1;
                    end
                    if (t_small || !wnx_in) begin
                        n_state = S_FIT;
                    end else begin
                        n_w  = wnx[IDX_W-1:0];
                        n_ra = wnx[IDX_W-1:0];
                    end
                end
            end
            S_FIT: begin
                if (r_found) begin
                    if (r_best > 32'(r_need)) begin
                        n_state = S_SPL1;
                    end else if (nxtp < 32'(r_top)) begin
                        n_ra    = nxtp[IDX_W-1:0];
                        n_state = S_NXTWR;
                    end else begin
                        n_state = S_SPL3;
                    end
                end else if (({r_top, 2'b00} + 32'(r_need)) > 32'(HEAP_WORDS * 4)) begin
                    n_res_stat = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    n_ra    = r_last[IDX_W-1:0];
                    n_state = S_GROW;
                end
            end
            S_SPL1: begin
                // Remainder becomes a free block right after the grant.
                n_we = 1'b1;  n_wa = nxtp[IDX_W-1:0];  n_wd = r_best - 32'(r_need);
                if (TOP_W'(r_p) == r_last) n_last = TOP_W'(nxtp[IDX_W-1:0]);
                n_state = S_SPL2;
            end
            S_SPL2: begin
                n_we = (sft < 32'(HEAP_WORDS));
                n_wa = sft[IDX_W-1:0];
                n_wd = r_best - 32'(r_need);
                n_state = S_SPL3;
            end
            S_NXTWR: begin
                n_we = 1'b1;  n_wa = nxtp[IDX_W-1:0];  n_wd = r_rd & ~TAG_PREVFREE;
                n_state = S_SPL3;
            end
            S_SPL3: begin
                n_we = 1'b1;  n_wa = r_p;  n_wd = 32'(r_need) | TAG_USED;
                do_adone = 1'b1;
            end
            S_GROW: begin
                n_we = 1'b1;
                n_wa = r_top[IDX_W-1:0];
                n_wd = 32'(r_need) | TAG_USED
                       | ((r_top != '0 && !r_rd[0]) ? TAG_PREVFREE : 32'd0);
                n_last   = r_top;
                n_top    = r_top + TOP_W'(r_need[16:2]);
                ap       = r_top[IDX_W-1:0];
                do_adone = 1'b1;
            end
            S_RESZ: begin
                if (os >= 32'(OVERHEAD) && 32'(r_req) < os - 32'(OVERHEAD)) begin
                    n_res_addr = r_addr;
                    n_res_pres = 1'b1;
                    n_state    = S_FIN;
                end else begin
                    n_move = 1'b1;
                    do_fit = 1'b1;
                end
            end
            S_RELRD: begin
                n_size   = t_sz;
                n_islast = (TOP_W'(r_h) == r_last);
                if (r_rd[1] && r_h != '0) begin
                    n_ra    = r_h - IDX_W'(1);
                    n_state = S_RELPRV;
                end else begin
                    n_state = S_RELMID;
                end
            end
            S_RELPRV: begin
                // Merge with a free block in front.
                if (r_rd[31:2] != 30'd0 && 32'(r_rd[31:2]) <= 32'(r_h)) begin
                    n_size = r_size + t_sz;
                    n_h    = r_h - r_rd[IDX_W+1:2];
                end
                n_state = S_RELMID;
            end
            S_RELMID: begin
                if (rnx < 32'(r_top)) begin
                    n_ra    = rnx[IDX_W-1:0];
                    n_state = S_RELNXT;
                end else begin
                    n_state = S_RELW1;
                end
            end
            S_RELNXT: begin
                if (!r_rd[0]) begin
                    if (rnx[TOP_W-1:0] == r_last) n_islast = 1'b1;
                    n_size = r_size + t_sz;
                end else begin
                    n_we = 1'b1;  n_wa = rnx[IDX_W-1:0];  n_wd = r_rd | TAG_PREVFREE;
                end
                n_state = S_RELW1;
            end
            S_RELW1: begin
                if (r_islast) n_last = TOP_W'(r_h);
                n_we = 1'b1;  n_wa = r_h;  n_wd = r_size;
                n_state = S_RELW2;
            end
            S_RELW2: begin
                n_we = (r_size[31:2] != 30'd0) && (rft < 32'(HEAP_WORDS));
                n_wa = rft[IDX_W-1:0];
                n_wd = r_size;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_o_addr = r_res_addr;  n_o_pres = r_res_pres;
                    n_o_stat = r_res_stat;  n_o_mov  = r_res_mov;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // Start a best-fit walk from the first block.
        if (do_fit) begin
            n_best = '1;  n_found = 1'b0;  n_find = 1'b0;  n_w = '0;
            if (r_top != '0) begin
                n_ra = '0;  n_state = S_WALK;
            end else begin
                n_state = S_FIT;
            end
        end
        // Start a walk that checks the named block.
        if (do_find) begin
            n_find = 1'b1;  n_w = '0;
            if (r_top != '0) begin
                n_ra = '0;  n_state = S_WALK;
            end else begin
                n_state = S_FIN;
            end
        end
        // Grant done; a relocating resize then frees the old block.
        if (do_adone) begin
            n_res_addr = {ap, 2'b00} + 14'(OVERHEAD);
            n_res_pres = 1'b1;
            if (r_move) begin
                n_res_mov = 1'b1;
                n_ra      = r_h;
                n_state   = S_RELRD;
            end else begin
                n_state = S_FIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        r_rd <= r_mem[n_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_top    <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_top    <= n_top;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;  r_h <= n_h;  r_p <= n_p;
        r_find <= n_find;  r_resz <= n_resz;  r_move <= n_move;  r_found <= n_found;
        r_best <= n_best;  r_need <= n_need;  r_req <= n_req;  r_addr <= n_addr;
        r_size <= n_size;  r_islast <= n_islast;
        r_res_addr <= n_res_addr;  r_res_pres <= n_res_pres;
        r_res_stat <= n_res_stat;  r_res_mov <= n_res_mov;
        r_o_addr <= n_o_addr;  r_o_pres <= n_o_pres;
        r_o_stat <= n_o_stat;  r_o_mov <= n_o_mov;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_result_addr    = r_o_addr;
    assign o_result_present = r_o_pres;
    assign o_status         = r_o_stat;
    assign o_moved          = r_o_mov;

endmodule

`default_nettype wire

// File: hw/rtl/bfa_checker.sv
`default_nettype none

module bfa_checker
    import bfa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [13:0] o_result_addr,
    input wire logic        o_result_present,
    input wire logic        o_status,
    input wire logic        o_moved
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_addr))
        else $error("result word changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("engine still ready after taking a word");

    a_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result_present |-> o_result_addr == 14'd0)
        else $error("null result with nonzero address");

    a_moved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_moved |-> o_result_present && !o_status)
        else $error("move flagged without a grant");

    a_oom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_result_present)
        else $error("out of memory with a grant");

endmodule

bind best_fit_boundary_tag_allocator bfa_checker u_bfa_checker (.*);

`default_nettype wire
